FILE: hw/rtl/postorder_to_join_order_assert.svh
// Assertion macros used by the RTL of the post-order join converter.
`ifndef POSTORDER_TO_JOIN_ORDER_ASSERT_SVH
`define POSTORDER_TO_JOIN_ORDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTJO_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTJO_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/ptjo_pkg.sv
`default_nettype none

package ptjo_pkg;

   localparam int CFG_W     = 11;
   localparam int IDX_W     = 10;
   localparam int NODE_W    = 11;
   localparam int JOINS_W   = 10;
   localparam int EPOCH_W   = 8;
   localparam int SEEN_MAX  = 1024;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_RANGE     = 2'd1,
      STATUS_REPEAT    = 2'd2,
      STATUS_STACK     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      STACK_HOLD,
      STACK_PUSH,
      STACK_JOIN,
      STACK_CLEAR
   } stack_op_type;

   typedef struct packed {
      stack_op_type        op;
      logic [NODE_W-1:0]   value;
   } stack_cmd_type;

   typedef struct packed {
      logic                is_leaf;
      logic [IDX_W-1:0]    leaf_index;
   } req_type;

   typedef struct packed {
      logic                join_valid;
      logic [NODE_W-1:0]   first_index;
      logic [NODE_W-1:0]   second_index;
      logic [NODE_W-1:0]   join_node;
      logic                root_done;
      status_type          status;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hw/rtl/ptjo_node_stack.sv
`default_nettype none

module ptjo_node_stack #(
   parameter int MAX_LEAVES = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ptjo_pkg::stack_cmd_type              cmd,
   output logic [ptjo_pkg::NODE_W-1:0]          top,
   output logic [ptjo_pkg::NODE_W-1:0]          below,
   output logic [$clog2(MAX_LEAVES+1)-1:0]      depth
);
   import ptjo_pkg::*;

   localparam int AW = $clog2(MAX_LEAVES);
   localparam int DW = $clog2(MAX_LEAVES + 1);

   // The top three entries live in registers; the rest sit in the memory.
   logic [NODE_W-1:0] mem [MAX_LEAVES];

   logic [NODE_W-1:0] top_ff, top_in;
   logic [NODE_W-1:0] below_ff, below_in;
   logic [NODE_W-1:0] third_ff, third_in;
   logic [NODE_W-1:0] rd_ff;
   logic [DW-1:0]     depth_ff, depth_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;
   logic [31:0]       wr_ptr;
   logic [31:0]       rd_ptr;

   always_comb begin
      top_in   = top_ff;
      below_in = below_ff;
      third_in = third_ff;
      depth_in = depth_ff;
      wr_en    = 1'b0;
      unique case (cmd.op)
         STACK_PUSH: begin
            top_in   = cmd.value;
            below_in = top_ff;
            third_in = below_ff;
            depth_in = depth_ff + DW'(1);
            wr_en    = 32'(depth_ff) >= 32'd3;
         end
         STACK_JOIN: begin
            top_in   = cmd.value;
            below_in = third_ff;
            third_in = rd_ff;
            depth_in = depth_ff - DW'(1);
         end
         STACK_CLEAR: begin
            depth_in = '0;
         end
         STACK_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   // The read port always fetches the entry just below the register cache.
   assign wr_ptr  = 32'(depth_ff) - 32'd3;
   assign rd_ptr  = 32'(depth_in) - 32'd4;
   assign wr_addr = wr_ptr[AW-1:0];
   assign rd_addr = rd_ptr[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= third_ff;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_ff <= third_ff;
      end else begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      top_ff   <= top_in;
      below_ff <= below_in;
      third_ff <= third_in;
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   assign top   = top_ff;
   assign below = below_ff;
   assign depth = depth_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/postorder_to_join_order.sv
// Converts a binary tree, presented one node per beat in post-order, into
// its list of pairwise joins. Every accepted beat yields exactly one result
// beat, via the input and response registers, and a new beat can be
// accepted on every cycle while req_stall is low; leaf checks use a tagged
// seen table and the node stack keeps its top three entries in registers,
// so back-to-back joins and pushes run at full rate. After reset, and again
// after every 255th completed tree, the seen table is swept clean, one
// entry per cycle; req_stall stays high, yet leaf_count writes are still
// taken. leaf_count is clamped to the range 2 to MAX_LEAVES when written and
// should only be written while no beat is in flight.
`default_nettype none

`include "postorder_to_join_order_assert.svh"

module postorder_to_join_order #(
   parameter int MAX_LEAVES = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  ptjo_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output ptjo_pkg::rsp_type            rsp_data,
   input  logic                         csr_we,
   input  logic [ptjo_pkg::CFG_W-1:0]   csr_wdata
);
   import ptjo_pkg::*;

   localparam int DW         = $clog2(MAX_LEAVES + 1);
   localparam int SEEN_DEPTH = (MAX_LEAVES < SEEN_MAX) ? MAX_LEAVES : SEEN_MAX;
   localparam int SAW        = $clog2(SEEN_DEPTH);

   logic [EPOCH_W-1:0] seen_mem [SEEN_DEPTH];

   logic [DW-1:0]      leaves_ff, leaves_in;
   logic               in_valid_ff;
   req_type            in_data_ff;
   logic [EPOCH_W-1:0] seen_rd_ff;
   logic               stale_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   logic [JOINS_W-1:0] joins_ff, joins_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic               clearing_ff, clearing_in;
   logic [SAW-1:0]     clr_ptr_ff, clr_ptr_in;

   logic               advance;
   logic               accept;
   logic [31:0]        csr_wide;
   logic [31:0]        leaves_wide;
   logic [31:0]        idx_wide;
   logic [31:0]        depth_wide;
   logic [31:0]        node_sum;
   logic               in_range;
   logic               seen_hit;
   logic               is_root;
   logic [NODE_W-1:0]  node_num;
   rsp_type            rsp_next;
   stack_op_type       op_next;
   stack_cmd_type      stack_cmd;
   logic               seen_push;
   logic               seen_we;
   logic [SAW-1:0]     seen_waddr;
   logic [EPOCH_W-1:0] seen_wdata;
   logic [SAW-1:0]     seen_raddr;
   logic [NODE_W-1:0]  stack_top;
   logic [NODE_W-1:0]  stack_below;
   logic [DW-1:0]      stack_depth;

   ptjo_node_stack #(
      .MAX_LEAVES (MAX_LEAVES)
   ) u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (stack_cmd),
      .top   (stack_top),
      .below (stack_below),
      .depth (stack_depth)
   );

   assign advance   = in_valid_ff && !clearing_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clearing_ff || (in_valid_ff && !advance);
   assign accept    = req_valid && !req_stall;

   assign csr_wide = 32'(csr_wdata);

   always_comb begin
      if (csr_wide < 32'd2) begin
         leaves_in = DW'(2);
      end else if (csr_wide > 32'(MAX_LEAVES)) begin
         leaves_in = DW'(MAX_LEAVES);
      end else begin
         leaves_in = csr_wide[DW-1:0];
      end
   end

   assign leaves_wide = 32'(leaves_ff);
   assign idx_wide    = 32'(in_data_ff.leaf_index);
   assign depth_wide  = 32'(stack_depth);
   assign node_sum    = leaves_wide + 32'(joins_ff);
   assign node_num    = node_sum[NODE_W-1:0];
   assign in_range    = idx_wide < leaves_wide;
   assign seen_hit    = !stale_ff && (seen_rd_ff == epoch_ff);
   assign is_root     = (32'(joins_ff) + 32'd1) >= (leaves_wide - 32'd1);

   always_comb begin
      rsp_next  = '0;
      op_next   = STACK_HOLD;
      seen_push = 1'b0;
      if (in_data_ff.is_leaf) begin
         if (!in_range) begin
            rsp_next.status = STATUS_RANGE;
         end else if (seen_hit) begin
            rsp_next.status = STATUS_REPEAT;
         end else if (depth_wide >= 32'(MAX_LEAVES)) begin
            rsp_next.status = STATUS_STACK;
         end else begin
            op_next   = STACK_PUSH;
            seen_push = 1'b1;
         end
      end else begin
         if (depth_wide < 32'd2) begin
            rsp_next.status = STATUS_STACK;
         end else begin
            rsp_next.join_valid   = 1'b1;
            rsp_next.first_index  = stack_below;
            rsp_next.second_index = stack_top;
            rsp_next.join_node    = node_num;
            rsp_next.root_done    = is_root;
            op_next               = is_root ? STACK_CLEAR : STACK_JOIN;
         end
      end
   end

   always_comb begin
      stack_cmd.op    = advance ? op_next : STACK_HOLD;
      stack_cmd.value = in_data_ff.is_leaf ? NODE_W'(in_data_ff.leaf_index) : node_num;
   end

   always_comb begin
      joins_in    = joins_ff;
      epoch_in    = epoch_ff;
      clearing_in = clearing_ff;
      clr_ptr_in  = clr_ptr_ff;
      if (clearing_ff) begin
         clr_ptr_in = clr_ptr_ff + SAW'(1);
         if (32'(clr_ptr_ff) == 32'(SEEN_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
      if (stack_cmd.op == STACK_JOIN) begin
         joins_in = joins_ff + JOINS_W'(1);
      end else if (stack_cmd.op == STACK_CLEAR) begin
         joins_in = '0;
         if (epoch_ff == '1) begin
            epoch_in    = EPOCH_W'(1);
            clearing_in = 1'b1;
            clr_ptr_in  = '0;
         end else begin
            epoch_in = epoch_ff + EPOCH_W'(1);
         end
      end
   end

   // Tag zero never matches a live epoch, so the sweep writes zero.
   always_comb begin
      seen_we    = clearing_ff || (advance && seen_push);
      seen_waddr = clearing_ff ? clr_ptr_ff : in_data_ff.leaf_index[SAW-1:0];
      seen_wdata = clearing_ff ? '0 : epoch_ff;
   end

   assign seen_raddr = req_data.leaf_index[SAW-1:0];

   always_ff @(posedge clock) begin
      if (seen_we) begin
         seen_mem[seen_waddr] <= seen_wdata;
      end
      if (accept) begin
         if (seen_we && (seen_waddr == seen_raddr)) begin
            seen_rd_ff <= seen_wdata;
         end else begin
            seen_rd_ff <= seen_mem[seen_raddr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
      if (reset) begin
         leaves_ff    <= DW'(2);
         in_valid_ff  <= 1'b0;
         stale_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         joins_ff     <= '0;
         epoch_ff     <= EPOCH_W'(1);
         clearing_ff  <= 1'b1;
         clr_ptr_ff   <= '0;
      end else begin
         if (csr_we) begin
            leaves_ff <= leaves_in;
         end
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (clearing_ff) begin
            stale_ff <= 1'b1;
         end else if (accept) begin
            stale_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         joins_ff    <= joins_in;
         epoch_ff    <= epoch_in;
         clearing_ff <= clearing_in;
         clr_ptr_ff  <= clr_ptr_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PTJO_ASSERT_NEXT(a_root_clears, stack_cmd.op == STACK_CLEAR, (stack_depth == '0) && (joins_ff == '0), "root join did not clear the tree state")
   `PTJO_ASSERT_NEXT(a_push_grows, stack_cmd.op == STACK_PUSH, stack_depth == $past(stack_depth) + DW'(1), "leaf push did not grow the stack by one")
   `PTJO_ASSERT_NEXT(a_error_holds, advance && (rsp_next.status != STATUS_OK), $stable(stack_depth) && $stable(joins_ff), "rejected beat changed the tree state")
   `PTJO_ASSERT_SAME(a_no_work_in_sweep, clearing_ff, !advance && !accept, "beat processed during the seen table sweep")

endmodule

`default_nettype wire
